### sv/rfbshc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbshc_pkg
// Types, constants and helpers shared by the RFB handshake classifier.
// ----------------------------------------------------------------------------
package rfbshc_pkg;

    localparam int MAX_TYPES_DEF = 64;

    localparam int STATUS_W     = 2;
    localparam int MINOR_W      = 16;
    localparam int TYPE_COUNT_W = 7;
    localparam int IDX_W        = 4;
    localparam int CLASS_W      = 3;

    localparam logic [IDX_W-1:0] BANNER_LEN  = 4'd12;
    localparam logic [IDX_W-1:0] PREFIX_END  = 4'd4;
    localparam logic [IDX_W-1:0] FORM_END    = 4'd8;
    localparam logic [IDX_W-1:0] DIGITS_END  = 4'd11;
    localparam logic [IDX_W-1:0] LEGACY_HIGH = 4'd3;

    localparam logic [7:0] ASCII_ZERO      = 8'h30;
    localparam logic [7:0] TYPE_NONE       = 8'd1;
    localparam logic [7:0] TYPE_DES        = 8'd2;
    localparam logic [7:0] TYPE_STRONG_MIN = 8'd16;
    localparam logic [MINOR_W-1:0] LEGACY_MINOR_LIMIT = 16'd7;

    // class flag bit positions
    localparam int CF_NONE   = 0;
    localparam int CF_DES    = 1;
    localparam int CF_STRONG = 2;

    typedef enum logic [2:0] {
        PH_BANNER = 3'd0,
        PH_LEGACY = 3'd1,
        PH_COUNT  = 3'd2,
        PH_LIST   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOT_RFB = 2'd1,
        ST_CLOSED = 2'd2
    } status_t;

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_CLOSE = 1'b1
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        status_t                   status;
        logic                      legacy_format;
        logic [MINOR_W-1:0]        minor_version;
        logic [TYPE_COUNT_W-1:0]   type_count;
        logic                      offers_none;
        logic                      offers_des;
        logic                      offers_strong;
        logic                      no_auth_flag;
        logic                      weak_auth_flag;
    } result_t;

    // expected banner text "RFB 003." for the first eight bytes
    function automatic logic [7:0] banner_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h52;  // R
            3'd1:    c = 8'h46;  // F
            3'd2:    c = 8'h42;  // B
            3'd3:    c = 8'h20;  // space
            3'd4:    c = 8'h30;  // 0
            3'd5:    c = 8'h30;  // 0
            3'd6:    c = 8'h33;  // 3
            default: c = 8'h2e;  // .
        endcase
        return c;
    endfunction

    function automatic logic [CLASS_W-1:0] classify(input logic [7:0] t);
        logic [CLASS_W-1:0] f;
        f = '0;
        if (t == TYPE_NONE) begin
            f[CF_NONE] = 1'b1;
        end else if (t == TYPE_DES) begin
            f[CF_DES] = 1'b1;
        end else if (t >= TYPE_STRONG_MIN) begin
            f[CF_STRONG] = 1'b1;
        end
        return f;
    endfunction

endpackage

### sv/rfb_security_handshake_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfb_security_handshake_classifier_top
// Classifies the security types offered in the server side of an RFB handshake.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one server byte per item in s_tdata; s_tuser = 1 marks a
//   connection close, which restarts the parser (data byte ignored).
//   Result stream m_*: at most one result item per input item, issued when the
//   banner prefix fails, the security type list or legacy type completes, or the link closes early.
//   m_tuser carries the status code, m_tdata the version and type findings.
// Path: an item is registered in the input register on accept, parsed from there,
//   and its result is registered in the result register, which drives m_tvalid.
// Throughput: one item per cycle unless a result waits on m_tready; the per-byte
//   parser update is a single register-to-register step (a byte every cycle).
// Reset (aresetn low, synchronous): both stages empty, parser waits for the
//   first banner byte.
// Stall: while a result waits on m_tready, the parser holds and the input
//   register keeps one item; s_tready drops once that register is full.
// ----------------------------------------------------------------------------
module rfb_security_handshake_classifier_top
    import rfbshc_pkg::*;
#(
    parameter int MAX_TYPES = MAX_TYPES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] legacy_format, [16:1] minor_version,
                                   // [23:17] type_count, [24] offers_none,
                                   // [25] offers_des, [26] offers_strong,
                                   // [27] no_auth_flag, [28] weak_auth_flag
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic    out_free;
    logic    step;
    item_t   item;
    logic    res_valid;
    result_t res;
    result_t out_res;

    rfbshc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .step     (step),
        .item     (item)
    );

    rfbshc_parser #(
        .MAX_TYPES (MAX_TYPES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    rfbshc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_res  (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {3'd0,
                      out_res.weak_auth_flag,
                      out_res.no_auth_flag,
                      out_res.offers_strong,
                      out_res.offers_des,
                      out_res.offers_none,
                      out_res.type_count,
                      out_res.minor_version,
                      out_res.legacy_format};

endmodule

### sv/rfbshc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbshc_in_stage
// Input register: captures one item and offers it to the parser.
// ----------------------------------------------------------------------------
module rfbshc_in_stage
    import rfbshc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       out_free,
    output logic       step,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // item moves on when the result slot is free
    assign step     = valid_reg && out_free;
    assign s_tready = !valid_reg || out_free;
    assign take     = s_tvalid && s_tready;
    assign item     = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (step) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.operation <= op_t'(s_tuser);
            item_reg.data_byte <= s_tdata;
        end
    end

endmodule

### sv/rfbshc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbshc_parser
// Handshake state and per-byte update; builds the result when one is due.
// ----------------------------------------------------------------------------
module rfbshc_parser
    import rfbshc_pkg::*;
#(
    parameter int MAX_TYPES = MAX_TYPES_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    localparam int TW = $clog2(MAX_TYPES + 1);
    localparam logic [7:0] MAX_B = 8'(MAX_TYPES);

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   byte_index_reg, byte_index_next;
    logic               prefix_match_reg, prefix_match_next;
    logic               form_ok_reg, form_ok_next;
    logic [MINOR_W-1:0] minor_accum_reg, minor_accum_next;
    logic [TW-1:0]      remaining_reg, remaining_next;
    logic [TW-1:0]      seen_reg, seen_next;
    logic               high_zero_reg, high_zero_next;
    logic [CLASS_W-1:0] class_reg, class_next;

    logic [7:0]         b;
    logic [IDX_W-1:0]   idx_inc;
    logic [MINOR_W-1:0] minor_val;
    logic               is_legacy;
    logic               emit_closed;
    logic               emit_not_rfb;
    logic               emit_ok;
    logic               legacy_done;

    assign b       = item.data_byte;
    assign idx_inc = byte_index_reg + 1'b1;
    // minor version as the banner left it (next-state value at the last byte)
    assign minor_val = form_ok_next ? minor_accum_next : '0;
    assign is_legacy = !minor_val[MINOR_W-1] && (minor_val < LEGACY_MINOR_LIMIT);

    // next state
    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        prefix_match_next = prefix_match_reg;
        form_ok_next      = form_ok_reg;
        minor_accum_next  = minor_accum_reg;
        remaining_next    = remaining_reg;
        seen_next         = seen_reg;
        high_zero_next    = high_zero_reg;
        class_next        = class_reg;
        emit_closed       = 1'b0;
        emit_not_rfb      = 1'b0;
        emit_ok           = 1'b0;
        legacy_done       = 1'b0;
        if (step) begin
            if (item.operation == OP_CLOSE) begin
                emit_closed       = (phase_reg != PH_DONE);
                phase_next        = PH_BANNER;
                byte_index_next   = '0;
                prefix_match_next = 1'b1;
                form_ok_next      = 1'b1;
                minor_accum_next  = '0;
                remaining_next    = '0;
                seen_next         = '0;
                high_zero_next    = 1'b1;
                class_next        = '0;
            end else begin
                case (phase_reg)
                    PH_BANNER: begin
                        if (byte_index_reg < PREFIX_END) begin
                            if (b != banner_char(byte_index_reg[2:0])) begin
                                prefix_match_next = 1'b0;
                            end
                        end else if (byte_index_reg < FORM_END) begin
                            if (b != banner_char(byte_index_reg[2:0])) begin
                                form_ok_next = 1'b0;
                            end
                        end else if (byte_index_reg < DIGITS_END) begin
                            // accum * 10 + (b - '0'), wrapping at 16 bits
                            minor_accum_next = (minor_accum_reg << 3)
                                             + (minor_accum_reg << 1)
                                             + {8'd0, b} - {8'd0, ASCII_ZERO};
                        end
                        byte_index_next = idx_inc;
                        if (idx_inc == BANNER_LEN) begin
                            byte_index_next = '0;
                            if (!prefix_match_next) begin
                                phase_next   = PH_DONE;
                                emit_not_rfb = 1'b1;
                            end else if (is_legacy) begin
                                phase_next = PH_LEGACY;
                            end else begin
                                phase_next = PH_COUNT;
                            end
                        end
                    end
                    PH_LEGACY: begin
                        if (byte_index_reg < LEGACY_HIGH) begin
                            if (b != 8'd0) begin
                                high_zero_next = 1'b0;
                            end
                            byte_index_next = idx_inc;
                        end else begin
                            byte_index_next = '0;
                            if (high_zero_reg) begin
                                seen_next  = TW'(1);
                                class_next = class_reg | classify(b);
                            end
                            emit_ok     = 1'b1;
                            legacy_done = 1'b1;
                            phase_next  = PH_DONE;
                        end
                    end
                    PH_COUNT: begin
                        if (b == 8'd0) begin
                            emit_ok    = 1'b1;
                            phase_next = PH_DONE;
                        end else begin
                            remaining_next = (b > MAX_B) ? TW'(MAX_B) : TW'(b);
                            phase_next     = PH_LIST;
                        end
                    end
                    PH_LIST: begin
                        class_next = class_reg | classify(b);
                        seen_next  = seen_reg + 1'b1;
                        if (remaining_reg != '0) begin
                            remaining_next = remaining_reg - 1'b1;
                        end
                        if (remaining_next == '0) begin
                            emit_ok    = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // result
    always_comb begin
        res       = '0;
        res_valid = emit_closed || emit_not_rfb || emit_ok;
        if (emit_closed) begin
            res.status = ST_CLOSED;
        end else if (emit_not_rfb) begin
            res.status = ST_NOT_RFB;
        end else begin
            res.status         = ST_OK;
            res.legacy_format  = legacy_done;
            res.minor_version  = form_ok_reg ? minor_accum_reg : '0;
            res.type_count     = TYPE_COUNT_W'(seen_next);
            res.offers_none    = class_next[CF_NONE];
            res.offers_des     = class_next[CF_DES];
            res.offers_strong  = class_next[CF_STRONG];
            res.no_auth_flag   = class_next[CF_NONE];
            res.weak_auth_flag = class_next[CF_DES] && !class_next[CF_STRONG];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_BANNER;
            byte_index_reg   <= '0;
            prefix_match_reg <= 1'b1;
            form_ok_reg      <= 1'b1;
            minor_accum_reg  <= '0;
            remaining_reg    <= '0;
            seen_reg         <= '0;
            high_zero_reg    <= 1'b1;
            class_reg        <= '0;
        end else begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            prefix_match_reg <= prefix_match_next;
            form_ok_reg      <= form_ok_next;
            minor_accum_reg  <= minor_accum_next;
            remaining_reg    <= remaining_next;
            seen_reg         <= seen_next;
            high_zero_reg    <= high_zero_next;
            class_reg        <= class_next;
        end
    end

    a_res_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> step)
        else $error("result without an item");

    a_ok_goes_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == ST_OK) |=> phase_reg == PH_DONE)
        else $error("parser not done after ok result");

    a_close_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && item.operation == OP_CLOSE) |=>
            (phase_reg == PH_BANNER && byte_index_reg == '0 && seen_reg == '0))
        else $error("close did not restart parser");

    a_list_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LIST |-> remaining_reg != '0)
        else $error("list phase with nothing remaining");

endmodule

### sv/rfbshc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfbshc_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module rfbshc_out_stage
    import rfbshc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    output logic    out_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign out_res  = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

### sim/rfb_handshake_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfb_handshake_checker
// Watches both streams of the RFB handshake classifier, runs its own parser
// on every accepted input item and compares each result item in order.
// ----------------------------------------------------------------------------
module rfb_handshake_checker
    import rfbshc_pkg::*;
#(
    parameter int MAX_TYPES = MAX_TYPES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [0] legacy_format, [16:1] minor_version,
                                   // [23:17] type_count, [24] offers_none,
                                   // [25] offers_des, [26] offers_strong,
                                   // [27] no_auth_flag, [28] weak_auth_flag
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          mismatches,
    output int          outstanding
);

    // "RFB 003." with the first character in the top byte
    localparam logic [63:0] BANNER_TEXT = "RFB 003.";

    result_t     findings_q[$];
    int          errors;

    phase_t      phase;
    logic [3:0]  byte_idx;
    logic        prefix_ok;
    logic        form_ok;
    logic [15:0] minor_acc;
    int          remaining;
    int          seen;
    logic        high_zero;
    logic        saw_none;
    logic        saw_des;
    logic        saw_strong;

    task automatic restart_parser();
        phase      = PH_BANNER;
        byte_idx   = '0;
        prefix_ok  = 1'b1;
        form_ok    = 1'b1;
        minor_acc  = '0;
        remaining  = 0;
        seen       = 0;
        high_zero  = 1'b1;
        saw_none   = 1'b0;
        saw_des    = 1'b0;
        saw_strong = 1'b0;
    endtask

    function automatic logic signed [15:0] minor_now();
        return form_ok ? $signed(minor_acc) : 16'sd0;
    endfunction

    task automatic note_type(input logic [7:0] t);
        if (t == TYPE_NONE) begin
            saw_none = 1'b1;
        end else if (t == TYPE_DES) begin
            saw_des = 1'b1;
        end else if (t >= TYPE_STRONG_MIN) begin
            saw_strong = 1'b1;
        end
    endtask

    task automatic finish_handshake(input logic legacy);
        result_t r;
        r = '0;
        r.status         = ST_OK;
        r.legacy_format  = legacy;
        r.minor_version  = minor_now();
        r.type_count     = 7'(seen);
        r.offers_none    = saw_none;
        r.offers_des     = saw_des;
        r.offers_strong  = saw_strong;
        r.no_auth_flag   = saw_none;
        r.weak_auth_flag = saw_des && !saw_strong;
        findings_q.push_back(r);
        phase = PH_DONE;
    endtask

    task automatic parse_item(input op_t op, input logic [7:0] b);
        result_t          r;
        logic signed [15:0] m;
        r = '0;
        if (op == OP_CLOSE) begin
            // a close always restarts; it reports only if no result came yet
            if (phase != PH_DONE) begin
                r.status = ST_CLOSED;
                findings_q.push_back(r);
            end
            restart_parser();
        end else begin
            case (phase)
                PH_BANNER: begin
                    if (byte_idx < 4'd4) begin
                        if (b != BANNER_TEXT[63 - 8*byte_idx -: 8]) prefix_ok = 1'b0;
                    end else if (byte_idx < 4'd8) begin
                        if (b != BANNER_TEXT[63 - 8*byte_idx -: 8]) form_ok = 1'b0;
                    end else if (byte_idx < 4'd11) begin
                        minor_acc = minor_acc * 16'd10 + (16'(b) - 16'd48);
                    end
                    byte_idx = byte_idx + 4'd1;
                    if (byte_idx == 4'd12) begin
                        byte_idx = '0;
                        if (!prefix_ok) begin
                            r.status = ST_NOT_RFB;
                            findings_q.push_back(r);
                            phase = PH_DONE;
                        end else begin
                            m = minor_now();
                            phase = (m >= 16'sd0 && m < 16'sd7) ? PH_LEGACY : PH_COUNT;
                        end
                    end
                end
                PH_LEGACY: begin
                    if (byte_idx < 4'd3) begin
                        if (b != 8'd0) high_zero = 1'b0;
                        byte_idx = byte_idx + 4'd1;
                    end else begin
                        byte_idx = '0;
                        // a type above 0xff is dropped
                        if (high_zero) begin
                            seen = 1;
                            note_type(b);
                        end
                        finish_handshake(1'b1);
                    end
                end
                PH_COUNT: begin
                    if (b == 8'd0) begin
                        finish_handshake(1'b0);
                    end else begin
                        remaining = (int'(b) > MAX_TYPES) ? MAX_TYPES : int'(b);
                        phase = PH_LIST;
                    end
                end
                PH_LIST: begin
                    note_type(b);
                    seen++;
                    if (remaining > 0) remaining--;
                    if (remaining == 0) finish_handshake(1'b0);
                end
                default: begin
                end
            endcase
        end
    endtask

    function automatic string show(input result_t r);
        return $sformatf({"status=%0d legacy=%0d minor=%0d count=%0d none=%0d des=%0d ",
                          "strong=%0d no_auth=%0d weak=%0d"},
                         r.status, r.legacy_format, $signed(r.minor_version), r.type_count,
                         r.offers_none, r.offers_des, r.offers_strong, r.no_auth_flag,
                         r.weak_auth_flag);
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            restart_parser();
        end else begin
            // results first: the item accepted at this edge cannot have one yet
            if (m_tvalid && m_tready) begin
                got = '0;
                got.status         = status_t'(m_tuser);
                got.legacy_format  = m_tdata[0];
                got.minor_version  = m_tdata[16:1];
                got.type_count     = m_tdata[23:17];
                got.offers_none    = m_tdata[24];
                got.offers_des     = m_tdata[25];
                got.offers_strong  = m_tdata[26];
                got.no_auth_flag   = m_tdata[27];
                got.weak_auth_flag = m_tdata[28];
                if (findings_q.size() == 0) begin
                    if (errors < 10) begin
                        $display("%0t: result with nothing pending: %s", $time, show(got));
                    end
                    errors++;
                end else begin
                    want = findings_q.pop_front();
                    if (got !== want || m_tdata[31:29] !== 3'b000) begin
                        if (errors < 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected %s", show(want));
                            $display("  actual   %s pad=%b", show(got), m_tdata[31:29]);
                        end
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_item(op_t'(s_tuser), s_tdata);
            end
        end
        outstanding <= findings_q.size();
        mismatches  <= errors;
    end

endmodule

### sim/tb_rfb_security_handshake_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rfb_security_handshake_classifier_top
// Feeds the classifier with whole and cut-short RFB handshakes: legacy and
// list forms, bad banners, odd version digits, capped counts and noise, under
// several sender and receiver idle patterns. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_rfb_security_handshake_classifier_top;
    import rfbshc_pkg::*;

    localparam int MAX_TYPES   = MAX_TYPES_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 315;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    int          mismatches;
    int          outstanding;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          idle_cycles   = 0;
    int          counted;
    logic [7:0]  session[$];

    always #5 aclk = ~aclk;

    rfb_security_handshake_classifier_top #(
        .MAX_TYPES (MAX_TYPES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rfb_handshake_checker #(
        .MAX_TYPES (MAX_TYPES)
    ) i_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic send_item(input op_t op, input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [7:0] pick_type();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return TYPE_NONE;
        if (sel < 50) return TYPE_DES;
        if (sel < 65) return 8'($urandom_range(16, 255));
        if (sel < 75) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    // minor < 0 puts three random bytes where the digits go
    task automatic add_banner(input bit prefix_bad, input bit form_bad, input int minor);
        logic [63:0] txt;
        int          pos;
        txt = "RFB 003.";
        if (prefix_bad) begin
            pos = $urandom_range(0, 3);
            txt[63 - 8*pos -: 8] = txt[63 - 8*pos -: 8] ^ 8'($urandom_range(1, 255));
        end
        if (form_bad) begin
            pos = $urandom_range(4, 7);
            txt[63 - 8*pos -: 8] = txt[63 - 8*pos -: 8] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < 8; i++) session.push_back(txt[63 - 8*i -: 8]);
        if (minor < 0) begin
            repeat (3) session.push_back(8'($urandom_range(0, 255)));
        end else begin
            session.push_back(8'(ASCII_ZERO + minor / 100));
            session.push_back(8'(ASCII_ZERO + (minor / 10) % 10));
            session.push_back(8'(ASCII_ZERO + minor % 10));
        end
        // twelfth banner byte is not parsed
        session.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_legacy_type();
        repeat (3) begin
            session.push_back(($urandom_range(0, 99) < 80) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
        session.push_back(pick_type());
    endtask

    task automatic add_type_list();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 10)      n = 0;
        else if (sel < 14) n = MAX_TYPES;
        else if (sel < 20) n = $urandom_range(MAX_TYPES + 1, 255);
        else               n = $urandom_range(1, 8);
        session.push_back(8'(n));
        repeat ((n > MAX_TYPES) ? MAX_TYPES : n) session.push_back(pick_type());
    endtask

    // one connection: some handshake, maybe cut short, always ended by a close
    task automatic run_session();
        int kind;
        int cut;
        session.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 16)) session.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 14) begin
            add_banner(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, 999));
        end else if (kind < 30) begin
            add_banner(1'b0, 1'b0, $urandom_range(0, 6));
            add_legacy_type();
        end else if (kind < 40) begin
            add_banner(1'b0, 1'b1, $urandom_range(0, 999));
            add_legacy_type();
        end else if (kind < 50) begin
            // unknown minor: 00 00 00 t ends either form
            add_banner(1'b0, 1'b0, -1);
            repeat (3) session.push_back(8'h00);
            session.push_back(pick_type());
        end else begin
            add_banner(1'b0, 1'b0, $urandom_range(7, 999));
            add_type_list();
        end
        cut = session.size();
        if ($urandom_range(0, 99) < 25) cut = $urandom_range(0, session.size() - 1);
        for (int i = 0; i < cut; i++) send_item(OP_DATA, session[i]);
        counted += cut + 1;
        // trailing bytes after a finished handshake are ignored
        if (kind >= 8 && cut == session.size() && $urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) send_item(OP_DATA, 8'($urandom_range(0, 255)));
        end
        send_item(OP_CLOSE, 8'($urandom_range(0, 255)));
    endtask

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct <= 0;
                    stall_pct     <= 0;
                end
                1: begin
                    send_idle_pct <= 59;
                    stall_pct     <= 0;
                end
                2: begin
                    send_idle_pct <= 0;
                    stall_pct     <= 59;
                end
                default: begin
                    send_idle_pct <= 36;
                    stall_pct     <= 36;
                end
            endcase
            counted = 0;
            if (ph == 0) begin
                // close before any byte, then a list handshake with none, DES
                // and the top type value, a stray byte and a close after it
                send_item(OP_CLOSE, 8'hff);
                session.delete();
                add_banner(1'b0, 1'b0, 8);
                session.push_back(8'd3);
                session.push_back(TYPE_NONE);
                session.push_back(TYPE_DES);
                session.push_back(8'hff);
                foreach (session[i]) send_item(OP_DATA, session[i]);
                send_item(OP_DATA, 8'h00);
                send_item(OP_CLOSE, 8'h00);
                counted += 19;

                // back-to-back closes against a stalled receiver
                hold_requests <= hold_requests + 1;
                repeat (16) send_item(OP_CLOSE, 8'($urandom_range(0, 255)));
                counted += 16;
            end
            while (counted < PHASE_ITEMS) run_session();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
